>>> src/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside of reset.
`define TMA_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("tma assertion failed");

// Check that a trigger is followed by a condition in the next cycle.
`define TMA_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("tma assertion failed");

`endif

>>> src/tma_pkg.sv
package tma_pkg;

    localparam int RING_DEPTH  = 16;
    localparam int READING_W   = 13;
    localparam int WORD_W      = 16;
    localparam int SCALE_SHIFT = 4;     // quarter degree to 1/64 degree
    localparam int AVG_W       = 17;
    localparam int AVG_MAX     = ((1 << READING_W) - 1) << SCALE_SHIFT;

    localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int COUNT_W    = $clog2(RING_DEPTH + 1);
    localparam int TOTAL_W    = $clog2(RING_DEPTH * ((1 << READING_W) - 1) + 1);
    localparam int DIVIDEND_W = TOTAL_W + SCALE_SHIFT;
    localparam int STEP_W     = $clog2(DIVIDEND_W + 1);

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef struct packed {
        logic              command;
        logic [WORD_W-1:0] sensor_word;
        logic              read_failed;
    } t_in_item;

    typedef struct packed {
        logic [AVG_W-1:0] average_temp;
        logic             no_data;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SAMPLE,
        S_DIV,
        S_DONE
    } t_state;

endpackage

>>> src/tma_divider.sv
module tma_divider
    import tma_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [COUNT_W-1:0]    i_divisor,
    output logic                  o_done,
    output logic [AVG_W-1:0]      o_quotient
);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_cnt;
    logic [COUNT_W:0]      r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [COUNT_W-1:0]    r_div;

    logic [COUNT_W:0]      w_shift;
    logic [COUNT_W:0]      w_diff;
    logic                  w_fit;

    // Restoring division, one quotient bit a cycle.
    assign w_shift = {r_rem[COUNT_W-1:0], r_quo[DIVIDEND_W-1]};
    assign w_diff  = w_shift - {1'b0, r_div};
    assign w_fit   = (w_shift >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff : w_shift;
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[AVG_W-1:0];

endmodule

>>> src/thermocouple_moving_average_core.sv
// Thermocouple moving average core.
// Input channel (i_valid / o_ready / i_data) carries commands. A sample
// command stores the low 13 bits of sensor_word (quarter degrees) in a
// 16-entry ring, dropping the oldest entry when the ring is full; a sample
// with read_failed set empties the ring instead. A sample is only taken
// while the sample enable flag is set, and taking it clears the flag; a
// sample arriving while the flag is clear is accepted and dropped.
// A read command sets the flag again and produces one output item on
// (o_valid / i_ready / o_data): the mean in 1/64 degree, or no_data = 1
// when the ring is empty. Sample commands produce no output.
// Timing: a sample passes through S_SAMPLE before the core is idle again.
// A read of a non-empty ring runs a restoring divider, one quotient bit
// per cycle over the 21-bit scaled total, then moves the result through
// S_DONE into the output register; an empty read goes straight to S_DONE.
// One item is in flight at a time and o_ready is high only while the
// sequencer is idle. The output register holds a result until taken; the
// core keeps taking commands meanwhile and waits only when a new result
// must be loaded.
// Reset empties the ring (count, oldest slot, total), drops any output
// item and sets the flag.
module thermocouple_moving_average_core
    import tma_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    t_state              r_state, n_state;
    logic                r_enable, n_enable;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [SLOT_W-1:0]   r_oldest, n_oldest;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic                r_out_valid, n_out_valid;

    // Payload held without reset.
    logic [READING_W-1:0] r_word;
    logic                 r_failed;
    t_out_item            r_pend, n_pend;
    t_out_item            r_out_data, n_out_data;
    logic                 n_load_pend;

    // Ring memory with registered read at the oldest slot.
    logic [READING_W-1:0] r_ring [RING_DEPTH];
    logic [READING_W-1:0] r_rd_data;
    logic                 w_wr_en;
    logic [SLOT_W-1:0]    w_wr_slot;

    logic                 w_accept;
    logic                 w_full;
    logic [SLOT_W:0]      w_slot_sum;
    logic                 w_div_start;
    logic                 w_div_done;
    logic [AVG_W-1:0]     w_quotient;

    assign w_accept = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign w_full   = (r_count == COUNT_W'(RING_DEPTH));

    // Next free slot: oldest plus count, wrapped once.
    assign w_slot_sum = {1'b0, r_oldest} + {1'b0, r_count[SLOT_W-1:0]};
    always_comb begin
        if (w_full) begin
            w_wr_slot = r_oldest;
        end else if (w_slot_sum >= (SLOT_W + 1)'(RING_DEPTH)) begin
            w_wr_slot = SLOT_W'(w_slot_sum - (SLOT_W + 1)'(RING_DEPTH));
        end else begin
            w_wr_slot = w_slot_sum[SLOT_W-1:0];
        end
    end

    assign w_wr_en = (r_state == S_SAMPLE) && !r_failed;

    assign w_div_start = w_accept && (i_data.command == CMD_READ) && (r_count != '0);

    tma_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({r_total, SCALE_SHIFT'(0)}),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_comb begin
        n_state     = r_state;
        n_enable    = r_enable;
        n_count     = r_count;
        n_oldest    = r_oldest;
        n_total     = r_total;
        n_pend      = r_pend;
        n_load_pend = 1'b0;
        n_out_valid = r_out_valid && !i_ready;
        n_out_data  = r_out_data;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_data.command == CMD_READ) begin
                        n_enable = 1'b1;
                        if (r_count == '0) begin
                            n_pend.average_temp = '0;
                            n_pend.no_data      = 1'b1;
                            n_load_pend         = 1'b1;
                            n_state             = S_DONE;
                        end else begin
                            n_state = S_DIV;
                        end
                    end else if (r_enable) begin
                        // Take the sample and close the gate until the next read.
                        n_enable = 1'b0;
                        n_state  = S_SAMPLE;
                    end
                end
            end
            S_SAMPLE: begin
                if (r_failed) begin
                    n_count  = '0;
                    n_oldest = '0;
                    n_total  = '0;
                end else if (w_full) begin
                    // Drop the oldest entry and reuse its slot.
                    n_total  = r_total - TOTAL_W'(r_rd_data) + TOTAL_W'(r_word);
                    n_oldest = (r_oldest == SLOT_W'(RING_DEPTH - 1)) ? '0 : r_oldest + 1'b1;
                end else begin
                    n_total = r_total + TOTAL_W'(r_word);
                    n_count = r_count + 1'b1;
                end
                n_state = S_IDLE;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_pend.average_temp = w_quotient;
                    n_pend.no_data      = 1'b0;
                    n_load_pend         = 1'b1;
                    n_state             = S_DONE;
                end
            end
            S_DONE: begin
                // Hold the result until the output register is free.
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_pend;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enable    <= 1'b1;
            r_count     <= '0;
            r_oldest    <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_enable    <= n_enable;
            r_count     <= n_count;
            r_oldest    <= n_oldest;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_word   <= i_data.sensor_word[READING_W-1:0];
            r_failed <= i_data.read_failed;
        end
        if (n_load_pend) begin
            r_pend <= n_pend;
        end
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_ring[w_wr_slot] <= r_word;
        end
        r_rd_data <= r_ring[r_oldest];
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

>>> src/tma_checker.sv
`include "assert_macros.svh"

module tma_checker
    import tma_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input t_in_item  i_data,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_item o_data
);

    // A stalled result holds.
    `TMA_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_data))

    // An empty ring reports zero.
    `TMA_ASSERT_ALWAYS(a_empty_zero, !(o_valid && o_data.no_data) || (o_data.average_temp == '0))

    // The mean never exceeds a full-scale reading.
    `TMA_ASSERT_ALWAYS(a_avg_range, !o_valid || (o_data.average_temp <= AVG_MAX[AVG_W-1:0]))

    // A read command keeps the core busy for at least the next cycle.
    `TMA_ASSERT_NEXT(a_read_busy, i_valid && o_ready && (i_data.command == CMD_READ), !o_ready)

endmodule

bind thermocouple_moving_average_core tma_checker u_tma_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
